>>> rtl/pls_pkg.sv
// Shared widths, reset values and register indexes of the line steering controller.
package pls_pkg;

  // Field and register widths
  localparam int unsigned BRIGHT_W   = 8;
  localparam int unsigned THRESH_W   = 8;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned LIMIT_W    = 7;
  localparam int unsigned TURN_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Error and error-change widths (threshold minus brightness, and its change)
  localparam int unsigned ERR_W  = 9;
  localparam int unsigned DIFF_W = 10;

  // Default parameter values
  localparam int unsigned ACC_WIDTH_DEF      = 24;
  localparam int unsigned GAIN_FRAC_BITS_DEF = 16;

  // Register reset values
  localparam logic [THRESH_W-1:0] THRESHOLD_RST     = 8'd50;
  localparam logic [GAIN_W-1:0]   PROP_GAIN_RST     = 24'd117965;
  localparam logic [GAIN_W-1:0]   INTEGRAL_GAIN_RST = 24'd1950;
  localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST    = 24'd1784218;
  localparam logic [LIMIT_W-1:0]  TURN_LIMIT_RST    = 7'd100;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD     = 3'd0,
    CFG_PROP_GAIN     = 3'd1,
    CFG_INTEGRAL_GAIN = 3'd2,
    CFG_DERIV_GAIN    = 3'd3,
    CFG_TURN_LIMIT    = 3'd4
  } cfg_idx_e;

endpackage

>>> rtl/pid_line_steering_core.sv
// PID steering controller top level: error, saturating sum, gain products and clamp.
//
// One brightness item enters per clock while in_stall_o is low, and one turn item
// leaves per item, in order. An item passes four register stages: error and
// saturating error sum, the three gain products (the integral product as two
// partial products), the scaled and signed terms, and the sum with clamp into the
// output register. Each stage holds only while the stage after it is full and
// stalled, so input is taken while a finished turn waits at the output as long
// as any stage is still empty. Configuration writes take effect on the next
// accepted item and are meant to be done with the pipeline empty.
module pid_line_steering_core #(
  parameter int unsigned ACC_WIDTH      = pls_pkg::ACC_WIDTH_DEF,
  parameter int unsigned GAIN_FRAC_BITS = pls_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [pls_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pls_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // sample input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pls_pkg::BRIGHT_W-1:0]      brightness_i,
  // steering output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [pls_pkg::TURN_W-1:0] turn_o
);
  import pls_pkg::*;

  localparam int unsigned SPLIT     = (ACC_WIDTH + 1) / 2;
  localparam int unsigned HI_W      = ACC_WIDTH - SPLIT;
  localparam int unsigned PROP_P_W  = GAIN_W + ERR_W;
  localparam int unsigned DER_P_W   = GAIN_W + DIFF_W;
  localparam int unsigned INT_LO_W  = GAIN_W + SPLIT;
  localparam int unsigned INT_HI_W  = GAIN_W + HI_W;
  localparam int unsigned INT_P_W   = GAIN_W + ACC_WIDTH;
  localparam int unsigned TERM_W    = INT_P_W + 1;
  localparam int unsigned TOT_W     = TERM_W + 2;

  // Configuration registers
  logic [THRESH_W-1:0] threshold_q;
  logic [GAIN_W-1:0]   prop_gain_q, integral_gain_q, deriv_gain_q;
  logic [LIMIT_W-1:0]  turn_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q     <= THRESHOLD_RST;
      prop_gain_q     <= PROP_GAIN_RST;
      integral_gain_q <= INTEGRAL_GAIN_RST;
      deriv_gain_q    <= DERIV_GAIN_RST;
      turn_limit_q    <= TURN_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD:     threshold_q     <= cfg_data_i[THRESH_W-1:0];
        CFG_PROP_GAIN:     prop_gain_q     <= cfg_data_i[GAIN_W-1:0];
        CFG_INTEGRAL_GAIN: integral_gain_q <= cfg_data_i[GAIN_W-1:0];
        CFG_DERIV_GAIN:    deriv_gain_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_TURN_LIMIT:    turn_limit_q    <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage handshake: a stage loads when it is empty or its successor loads
  logic va_q, vb_q, vc_q, out_valid_q;
  logic rd_a, rd_b, rd_c, rd_out;
  logic in_accept;

  assign rd_out    = !out_valid_q || !out_stall_i;
  assign rd_c      = !vc_q || rd_out;
  assign rd_b      = !vb_q || rd_c;
  assign rd_a      = !va_q || rd_b;
  assign in_stall_o = !rd_a;
  assign in_accept = in_valid_i && rd_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rd_a)   va_q        <= in_valid_i;
      if (rd_b)   vb_q        <= va_q;
      if (rd_c)   vc_q        <= vb_q;
      if (rd_out) out_valid_q <= vc_q;
    end
  end

  // Stage A: error, saturating error sum, error change
  logic [ERR_W-1:0]     err_w;
  logic [ACC_WIDTH:0]   sum_w;
  logic [ACC_WIDTH-1:0] sum_sat;
  logic [DIFF_W-1:0]    diff_w;
  logic [ACC_WIDTH-1:0] error_sum_q;
  logic [ERR_W-1:0]     last_error_q;

  always_comb begin
    err_w  = {1'b0, threshold_q} - {1'b0, brightness_i};
    sum_w  = {error_sum_q[ACC_WIDTH-1], error_sum_q}
           + {{(ACC_WIDTH + 1 - ERR_W){err_w[ERR_W-1]}}, err_w};
    if (sum_w[ACC_WIDTH] != sum_w[ACC_WIDTH-1]) begin
      sum_sat = sum_w[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                 : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end else begin
      sum_sat = sum_w[ACC_WIDTH-1:0];
    end
    diff_w = {err_w[ERR_W-1], err_w} - {last_error_q[ERR_W-1], last_error_q};
  end

  // Advance the controller state once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q  <= '0;
      last_error_q <= '0;
    end else if (in_accept) begin
      error_sum_q  <= sum_sat;
      last_error_q <= err_w;
    end
  end

  // Hold magnitudes and signs for the multipliers
  logic [ERR_W-1:0]     e_mag_q;
  logic [DIFF_W-1:0]    d_mag_q;
  logic [ACC_WIDTH-1:0] s_mag_q;
  logic                 e_neg_a_q, d_neg_a_q, s_neg_a_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      e_neg_a_q <= err_w[ERR_W-1];
      d_neg_a_q <= diff_w[DIFF_W-1];
      s_neg_a_q <= sum_sat[ACC_WIDTH-1];
      e_mag_q   <= err_w[ERR_W-1] ? (ERR_W'(0) - err_w) : err_w;
      d_mag_q   <= diff_w[DIFF_W-1] ? (DIFF_W'(0) - diff_w) : diff_w;
      s_mag_q   <= sum_sat[ACC_WIDTH-1] ? (ACC_WIDTH'(0) - sum_sat) : sum_sat;
    end
  end

  // Stage B: gain products, integral split into low and high partials
  logic [PROP_P_W-1:0] prop_p_q;
  logic [DER_P_W-1:0]  der_p_q;
  logic [INT_LO_W-1:0] int_lo_q;
  logic [INT_HI_W-1:0] int_hi_q;
  logic                e_neg_b_q, d_neg_b_q, s_neg_b_q;

  always_ff @(posedge clk_i) begin
    if (va_q && rd_b) begin
      prop_p_q  <= PROP_P_W'(prop_gain_q) * PROP_P_W'(e_mag_q);
      der_p_q   <= DER_P_W'(deriv_gain_q) * DER_P_W'(d_mag_q);
      int_lo_q  <= INT_LO_W'(integral_gain_q) * INT_LO_W'(s_mag_q[SPLIT-1:0]);
      int_hi_q  <= INT_HI_W'(integral_gain_q) * INT_HI_W'(s_mag_q[ACC_WIDTH-1:SPLIT]);
      e_neg_b_q <= e_neg_a_q;
      d_neg_b_q <= d_neg_a_q;
      s_neg_b_q <= s_neg_a_q;
    end
  end

  // Stage C: scale each product down and restore its sign
  logic [INT_P_W-1:0]  int_full;
  logic [PROP_P_W-1:0] prop_mag;
  logic [DER_P_W-1:0]  der_mag;
  logic [INT_P_W-1:0]  int_mag;
  logic [TERM_W-1:0]   prop_t_q, der_t_q, int_t_q;

  always_comb begin
    int_full = {int_hi_q, {SPLIT{1'b0}}} + INT_P_W'(int_lo_q);
    prop_mag = prop_p_q >> GAIN_FRAC_BITS;
    der_mag  = der_p_q >> GAIN_FRAC_BITS;
    int_mag  = int_full >> GAIN_FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (vb_q && rd_c) begin
      prop_t_q <= e_neg_b_q ? (TERM_W'(0) - TERM_W'(prop_mag)) : TERM_W'(prop_mag);
      der_t_q  <= d_neg_b_q ? (TERM_W'(0) - TERM_W'(der_mag)) : TERM_W'(der_mag);
      int_t_q  <= s_neg_b_q ? (TERM_W'(0) - TERM_W'(int_mag)) : TERM_W'(int_mag);
    end
  end

  // Stage D: add the terms and clamp to the turn limit
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  lim_pos, lim_neg;
  logic [TURN_W-1:0] turn_d;
  logic [TURN_W-1:0] turn_q;

  always_comb begin
    total   = {{2{prop_t_q[TERM_W-1]}}, prop_t_q}
            + {{2{der_t_q[TERM_W-1]}}, der_t_q}
            + {{2{int_t_q[TERM_W-1]}}, int_t_q};
    lim_pos = TOT_W'(turn_limit_q);
    lim_neg = TOT_W'(0) - lim_pos;
    if ($signed(total) > $signed(lim_pos)) begin
      turn_d = TURN_W'(turn_limit_q);
    end else if ($signed(total) < $signed(lim_neg)) begin
      turn_d = TURN_W'(0) - TURN_W'(turn_limit_q);
    end else begin
      turn_d = total[TURN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vc_q && rd_out) begin
      turn_q <= turn_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign turn_o      = $signed(turn_q);

endmodule

>>> rtl/pls_checker.sv
// Port-level checks for the line steering controller, bound to its top level.
module pls_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [pls_pkg::TURN_W-1:0] turn_o
);
  import pls_pkg::*;

  // A stalled turn item holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(turn_o))
  else $error("turn item changed while stalled");

  // The clamp keeps turn symmetric, so the most negative code never leaves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> turn_o != {1'b1, {(TURN_W-1){1'b0}}})
  else $error("turn outside symmetric limit");

  // With the output register empty the whole pipeline advances
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
  else $error("input stalled with empty output");

  // Input backpressure only comes with a stalled output item in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
  else $error("input stall without output backpressure");

endmodule

bind pid_line_steering_core pls_checker u_pls_checker (.*);
